@@ sv/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants for the sorted array priority queue: payload
// structs, operation and status codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int WIDTH  = 32;
    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // Operation codes carried in the mode field (code 3 acts as a peek)
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [WIDTH-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] head_value;
        logic                    head_valid;
        logic [CNT_W-1:0]        count;
        logic [1:0]              status;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_any;     // capture status code for this beat
        logic [1:0] status_code;
        logic       load_push;    // capture value, index starts at count
        logic       load_pop;     // index starts at one
        logic       rd_en;        // issue a store read (address picked by rd_pop)
        logic       rd_pop;       // read at next index (else next index - 1)
        logic       push_shift;   // move store[idx-1] up to store[idx]
        logic       push_place;   // write value at store[idx], count up
        logic       pop_move;     // move store[idx] down to store[idx-1]
        logic       pop_end;      // count down
        logic       out_load;     // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;     // count is zero
        logic one;       // count is one
        logic full;      // count is DEPTH
        logic idx_one;   // index is one
        logic greater;   // read entry is greater than the pushed value
        logic pop_more;  // another entry remains to move down
    } dp_stat_t;

endpackage

@@ sv/sapq_ram.sv @@
// ----------------------------------------------------------------------------
// sapq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sapq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/sapq_datapath.sv @@
// ----------------------------------------------------------------------------
// sapq_datapath
// Sorted store, fill count, head copy, walking index and result register.
// Performs one compare-and-move step per cycle under controller command.
// ----------------------------------------------------------------------------
module sapq_datapath
    import sapq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_item_t out_data
);

    logic signed [WIDTH-1:0] value_reg;
    logic signed [WIDTH-1:0] head_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        idx_next;
    logic [CNT_W-1:0]        count_reg;
    logic [1:0]              status_reg;
    out_item_t               out_reg;

    logic [CNT_W-1:0]        rd_idx;
    logic [ADDR_W-1:0]       rd_addr;
    logic [CNT_W-1:0]        wr_idx;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_en;
    logic [WIDTH-1:0]        wr_data;
    logic [WIDTH-1:0]        rd_data;

    // Walk the index: push walks down from count, pop walks up from one
    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.load_push)
        begin
            idx_next = count_reg;
        end
        else if (cmd.load_pop)
        begin
            idx_next = CNT_W'(1);
        end
        else if (cmd.push_shift)
        begin
            idx_next = idx_reg - CNT_W'(1);
        end
        else if (cmd.pop_move)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    // Read ahead at the entry the next step will need
    assign rd_idx  = cmd.rd_pop ? idx_next : (idx_next - CNT_W'(1));
    assign rd_addr = rd_idx[ADDR_W-1:0];

    // Write: shift up, place the new value, or shift down
    assign wr_en   = cmd.push_shift | cmd.push_place | cmd.pop_move;
    assign wr_idx  = cmd.pop_move ? (idx_reg - CNT_W'(1)) : idx_reg;
    assign wr_addr = wr_idx[ADDR_W-1:0];
    assign wr_data = cmd.push_place ? value_reg : rd_data;

    sapq_ram #(
        .WIDTH(WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state: fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.push_place)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (cmd.pop_end)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_push)
        begin
            value_reg <= in_data.value;
        end
        if (cmd.load_any)
        begin
            status_reg <= cmd.status_code;
        end
        // Keep a copy of entry zero
        if (cmd.push_place && (idx_reg == '0))
        begin
            head_reg <= value_reg;
        end
        else if (cmd.pop_move && (idx_reg == CNT_W'(1)))
        begin
            head_reg <= rd_data;
        end
        if (cmd.out_load)
        begin
            out_reg.head_value <= (count_reg != '0) ? head_reg : '0;
            out_reg.head_valid <= (count_reg != '0);
            out_reg.count      <= count_reg;
            out_reg.status     <= status_reg;
        end
    end

    // Status toward the controller
    assign stat.empty    = (count_reg == '0);
    assign stat.one      = (count_reg == CNT_W'(1));
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.idx_one  = (idx_reg == CNT_W'(1));
    assign stat.greater  = ($signed(rd_data) > value_reg);
    assign stat.pop_more = ((idx_reg + CNT_W'(1)) < count_reg);

    assign out_data = out_reg;

endmodule

@@ sv/sapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sapq_ctrl
// Controller state machine: decodes each input beat, sequences the insert
// and remove walks over the store, and owns the output valid.
// ----------------------------------------------------------------------------
module sapq_ctrl
    import sapq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    input  logic       out_ready,
    input  dp_stat_t   stat,
    output logic       in_ready,
    output logic       out_valid,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_PUSH_CMP   = 5'b00010,
        S_PUSH_PLACE = 5'b00100,
        S_POP_MOV    = 5'b01000,
        S_FINISH     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // Drop valid once the result beat is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_any    = 1'b1;
                    cmd.status_code = STATUS_DONE;
                    state_next      = S_FINISH;
                    if (in_mode == MODE_PUSH)
                    begin
                        if (stat.full)
                        begin
                            cmd.status_code = STATUS_FULL;
                        end
                        else
                        begin
                            cmd.load_push = 1'b1;
                            if (stat.empty)
                            begin
                                state_next = S_PUSH_PLACE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                state_next = S_PUSH_CMP;
                            end
                        end
                    end
                    else if (in_mode == MODE_POP)
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = STATUS_EMPTY;
                        end
                        else if (stat.one)
                        begin
                            cmd.pop_end = 1'b1;
                        end
                        else
                        begin
                            cmd.load_pop = 1'b1;
                            cmd.rd_en    = 1'b1;
                            cmd.rd_pop   = 1'b1;
                            state_next   = S_POP_MOV;
                        end
                    end
                end
            end

            // Move larger entries up one place until the slot is found
            S_PUSH_CMP:
            begin
                if (stat.greater)
                begin
                    cmd.push_shift = 1'b1;
                    if (stat.idx_one)
                    begin
                        state_next = S_PUSH_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                    end
                end
                else
                begin
                    cmd.push_place = 1'b1;
                    state_next     = S_FINISH;
                end
            end

            S_PUSH_PLACE:
            begin
                cmd.push_place = 1'b1;
                state_next     = S_FINISH;
            end

            // Move each entry down one place
            S_POP_MOV:
            begin
                cmd.pop_move = 1'b1;
                if (stat.pop_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pop = 1'b1;
                end
                else
                begin
                    cmd.pop_end = 1'b1;
                    state_next  = S_FINISH;
                end
            end

            // Hold until the result register is free
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ sv/sorted_array_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Minimum-first priority queue over a sorted store of DEPTH signed entries.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item_t  (mode, value)
//   out      output     out_valid/out_ready  out_item_t (head, count, status)
//
// A peek or a refused operation goes from idle straight to the finish state;
// a push moves each larger entry up one place, then writes the new value; a
// pop moves entries down. The walk does one read and one move per cycle.
// Reset clears the fill count, the state machine and the output valid; the
// store needs no clearing. A stalled output holds the finished result and
// the next beat is taken while it waits.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core
    import sapq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sapq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_data.mode),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    sapq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // Fill count never runs past capacity
    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.count <= CNT_W'(DEPTH)))
        else $error("count exceeds capacity");

    // Head flag agrees with the count
    a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.head_valid == (out_data.count != '0)))
        else $error("head_valid disagrees with count");

    // A dropped push only happens when full
    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STATUS_FULL))
            |-> (out_data.count == CNT_W'(DEPTH)))
        else $error("push dropped while not full");

    // An ignored pop only happens when empty
    a_empty_status : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STATUS_EMPTY))
            |-> (out_data.count == '0))
        else $error("pop ignored while not empty");
`endif

endmodule
